// ===== sv/stt_pkg.sv =====
// Shared types and codes of the software timer table.
package stt_pkg;

	// Command codes on the cmd field
	localparam logic [3:0] CMD_TICK      = 4'd0;
	localparam logic [3:0] CMD_NEW       = 4'd1;
	localparam logic [3:0] CMD_UPDATE    = 4'd2;
	localparam logic [3:0] CMD_UPD_NEW   = 4'd3;
	localparam logic [3:0] CMD_FREE      = 4'd4;
	localparam logic [3:0] CMD_FREE_OWN  = 4'd5;
	localparam logic [3:0] CMD_PAUSE     = 4'd6;
	localparam logic [3:0] CMD_RESUME    = 4'd7;
	localparam logic [3:0] CMD_READ      = 4'd8;

	// Result kinds
	localparam logic [1:0] KIND_EXPIRY = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_ACK    = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_KEY   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// Most results reported for one tick
	localparam logic [4:0] MAX_RES = 5'd16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_ACT,
		S_FLUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic next_slot;
		logic act;
		logic flush;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
		logic ev_block;
		logic pend_v;
	} dp_stat_t;

	// One result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [7:0]  owner;
		logic [7:0]  event_code;
		logic        func;
		logic [15:0] rem;
	} res_t;

endpackage

// ===== sv/stt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/stt_ctrl.sv =====
// Controller state machine of the software timer table.
module stt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output stt_pkg::ctrl_cmd_t   cmd,
	input  stt_pkg::dp_stat_t    stat
);
	stt_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			stt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = stt_pkg::S_RD;
				end
			end
			stt_pkg::S_RD: begin
				state_d = stt_pkg::S_EV;
			end
			stt_pkg::S_EV: begin
				cmd.eval = 1'b1;
				if (!stat.ev_block) begin
					if (stat.scan_last) begin
						state_d = stt_pkg::S_ACT;
					end else begin
						cmd.next_slot = 1'b1;
						state_d = stt_pkg::S_RD;
					end
				end
			end
			stt_pkg::S_ACT: begin
				cmd.act = 1'b1;
				state_d = stt_pkg::S_FLUSH;
			end
			stt_pkg::S_FLUSH: begin
				cmd.flush = 1'b1;
				if (!stat.pend_v || !stat.ev_block) begin
					state_d = stt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = stt_pkg::S_IDLE;
			end
		endcase
	end

	// Check scan sequencing
	a_load_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == stt_pkg::S_RD)
		else $error("load did not start a scan");
	a_rd_to_ev: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stt_pkg::S_RD |=> state_q == stt_pkg::S_EV)
		else $error("read not followed by evaluate");
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stt_pkg::S_FLUSH && !stat.pend_v) |=> in_ready)
		else $error("flush did not return to idle");
endmodule

// ===== sv/stt_dp.sv =====
// Datapath of the software timer table: slot store, scan and result registers.
module stt_dp #(
	parameter int SLOTS       = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stt_pkg::ctrl_cmd_t cmd,
	output stt_pkg::dp_stat_t  stat,
	input  logic [3:0]         cmd_in,
	input  logic [15:0]        time_value,
	input  logic               periodic,
	input  logic [7:0]         event_code,
	input  logic [7:0]         owner_id,
	input  logic               calls_function,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic [1:0]         status,
	output logic [3:0]         slot_index,
	output logic [7:0]         out_owner,
	output logic [7:0]         out_event,
	output logic               out_function,
	output logic [15:0]        remaining,
	output logic               last
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = COUNT_WIDTH;
	localparam int TW = (CW > 16) ? CW : 16;
	localparam int WW = 17 + 2 * CW;

	// Item registers
	logic [3:0]    cmd_q;
	logic [15:0]   tv_q;
	logic          per_q;
	logic [7:0]    ev_q;
	logic [7:0]    own_q;
	logic          fn_q;

	// Scan state
	logic [IW-1:0] idx_q;
	logic [SLOTS-1:0] valid_q, en_q;
	logic          key_f_q, free_f_q, any_q;
	logic [IW-1:0] key_idx_q, free_idx_q;
	logic [7:0]    key_own_q, key_ev_q;
	logic          key_fn_q;
	logic [CW-1:0] key_cnt_q;
	logic [4:0]    nres_q;

	// Result registers
	logic          pend_v_q, out_v_q, out_last_q;
	stt_pkg::res_t pend_q, out_q;

	// Slot store
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata, ram_rdata;

	stt_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	logic          r_fn;
	logic [7:0]    r_own, r_ev;
	logic [CW-1:0] r_rel, r_cnt;
	logic          cur_v, cur_en, is_tick, own_match, key_hit, expire, report;
	logic          out_free, ev_block, do_eval, ev_push, fl_push;
	logic [TW-1:0] tv_ext, cmax, cnt_ext;
	logic [CW-1:0] tsat, arm_cnt, arm_rel;
	logic [7:0]    arm_ev;
	logic [WW-1:0] arm_word;
	logic [15:0]   key_rem;
	stt_pkg::res_t exp_res, act_res;
	logic          act_res_v, act_arm, act_free, act_pause, act_resume;
	logic [IW-1:0] act_idx;

	// Unpack the slot read in the previous cycle
	assign r_fn  = ram_rdata[WW-1];
	assign r_own = ram_rdata[WW-2 -: 8];
	assign r_ev  = ram_rdata[WW-10 -: 8];
	assign r_rel = ram_rdata[2*CW-1:CW];
	assign r_cnt = ram_rdata[CW-1:0];

	// Per-slot evaluation
	assign cur_v     = valid_q[idx_q];
	assign cur_en    = en_q[idx_q];
	assign is_tick   = (cmd_q == stt_pkg::CMD_TICK);
	assign own_match = cur_v && (r_own == own_q) && (r_fn == fn_q);
	assign key_hit   = own_match && (fn_q || (r_ev == ev_q));
	assign expire    = is_tick && cur_v && cur_en && (r_cnt == '0);
	assign report    = (nres_q != stt_pkg::MAX_RES);
	assign out_free  = !out_v_q || out_ready;
	assign ev_block  = cmd.eval ? (expire && report && pend_v_q && !out_free)
	                            : (cmd.flush && pend_v_q && !out_free);
	assign do_eval   = cmd.eval && !ev_block;
	assign ev_push   = do_eval && expire && report && pend_v_q;
	assign fl_push   = cmd.flush && pend_v_q && out_free;

	assign stat.scan_last = (idx_q == IW'(SLOTS - 1));
	assign stat.ev_block  = ev_block;
	assign stat.pend_v    = pend_v_q;

	// Arming values: saturate the timeout to the count width
	assign tv_ext   = TW'(tv_q);
	assign cmax     = TW'({CW{1'b1}});
	assign tsat     = (tv_ext > cmax) ? CW'(cmax) : CW'(tv_ext);
	assign arm_cnt  = (tsat == '0) ? '0 : tsat - CW'(1);
	assign arm_rel  = per_q ? tsat : '0;
	assign arm_ev   = fn_q ? 8'd0 : ev_q;
	assign arm_word = {fn_q, own_q, arm_ev, arm_rel, arm_cnt};

	// Read reply count, saturated to 16 bits
	assign cnt_ext = TW'(key_cnt_q);
	assign key_rem = (cnt_ext > TW'(16'hFFFF)) ? 16'hFFFF : 16'(cnt_ext);

	always_comb begin
		exp_res = '0;
		exp_res.kind       = stt_pkg::KIND_EXPIRY;
		exp_res.status     = stt_pkg::ST_OK;
		exp_res.slot       = 4'(idx_q);
		exp_res.owner      = r_own;
		exp_res.event_code = r_fn ? 8'd0 : r_ev;
		exp_res.func       = r_fn;
	end

	// Decide the action that closes a command
	always_comb begin
		act_res    = '0;
		act_res.kind = stt_pkg::KIND_ACK;
		act_res_v  = 1'b1;
		act_arm    = 1'b0;
		act_free   = 1'b0;
		act_pause  = 1'b0;
		act_resume = 1'b0;
		act_idx    = key_idx_q;
		case (cmd_q)
			stt_pkg::CMD_NEW: begin
				act_idx = free_idx_q;
				if (free_f_q) begin
					act_arm = 1'b1;
					act_res.slot = 4'(free_idx_q);
				end else begin
					act_res.status = stt_pkg::ST_FULL;
				end
			end
			stt_pkg::CMD_UPDATE: begin
				if (key_f_q) begin
					act_arm = 1'b1;
					act_res.slot = 4'(key_idx_q);
				end else begin
					act_res.status = stt_pkg::ST_NO_KEY;
				end
			end
			stt_pkg::CMD_UPD_NEW: begin
				if (key_f_q) begin
					act_arm = 1'b1;
					act_res.slot = 4'(key_idx_q);
				end else if (free_f_q) begin
					act_arm = 1'b1;
					act_idx = free_idx_q;
					act_res.slot = 4'(free_idx_q);
				end else begin
					act_res.status = stt_pkg::ST_FULL;
				end
			end
			stt_pkg::CMD_FREE, stt_pkg::CMD_PAUSE, stt_pkg::CMD_RESUME: begin
				if (key_f_q) begin
					act_free   = (cmd_q == stt_pkg::CMD_FREE);
					act_pause  = (cmd_q == stt_pkg::CMD_PAUSE);
					act_resume = (cmd_q == stt_pkg::CMD_RESUME);
					act_res.slot = 4'(key_idx_q);
				end else begin
					act_res.status = stt_pkg::ST_NO_KEY;
				end
			end
			stt_pkg::CMD_FREE_OWN: begin
				act_res.status = any_q ? stt_pkg::ST_OK : stt_pkg::ST_NO_KEY;
			end
			stt_pkg::CMD_READ: begin
				act_res.kind = stt_pkg::KIND_READ;
				if (key_f_q) begin
					act_res.slot       = 4'(key_idx_q);
					act_res.owner      = key_own_q;
					act_res.event_code = key_fn_q ? 8'd0 : key_ev_q;
					act_res.func       = key_fn_q;
					act_res.rem        = key_rem;
				end else begin
					act_res.status = stt_pkg::ST_NO_KEY;
				end
			end
			default: begin
				act_res_v = 1'b0;
			end
		endcase
	end

	// Store write: tick count update during the scan, arming at the end
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {r_fn, r_own, r_ev, r_rel, r_cnt - CW'(1)};
		if (cmd.act) begin
			ram_we    = act_arm;
			ram_waddr = act_idx;
			ram_wdata = arm_word;
		end else if (do_eval && is_tick && cur_v && cur_en) begin
			if (expire) begin
				ram_we    = (r_rel != '0);
				ram_wdata = {r_fn, r_own, r_ev, r_rel, r_rel - CW'(1)};
			end else begin
				ram_we    = 1'b1;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			valid_q    <= '0;
			en_q       <= '0;
			key_f_q    <= 1'b0;
			free_f_q   <= 1'b0;
			any_q      <= 1'b0;
			key_idx_q  <= '0;
			free_idx_q <= '0;
			nres_q     <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			// Start a new word
			if (cmd.load) begin
				idx_q    <= '0;
				key_f_q  <= 1'b0;
				free_f_q <= 1'b0;
				any_q    <= 1'b0;
				nres_q   <= '0;
			end
			if (cmd.next_slot) begin
				idx_q <= idx_q + IW'(1);
			end
			// Scan one slot
			if (do_eval) begin
				if (key_hit && !key_f_q) begin
					key_f_q   <= 1'b1;
					key_idx_q <= idx_q;
				end
				if (!cur_v && !free_f_q) begin
					free_f_q   <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (cmd_q == stt_pkg::CMD_FREE_OWN && own_match) begin
					valid_q[idx_q] <= 1'b0;
					any_q <= 1'b1;
				end
				if (expire && (r_rel == '0)) begin
					valid_q[idx_q] <= 1'b0;
				end
				if (expire && report) begin
					nres_q   <= nres_q + 5'd1;
					pend_v_q <= 1'b1;
				end
			end
			// Close the command
			if (cmd.act) begin
				if (act_arm) begin
					valid_q[act_idx] <= 1'b1;
					en_q[act_idx]    <= 1'b1;
				end
				if (act_free) begin
					valid_q[act_idx] <= 1'b0;
				end
				if (act_pause) begin
					en_q[act_idx] <= 1'b0;
				end
				if (act_resume) begin
					en_q[act_idx] <= 1'b1;
				end
				if (act_res_v) begin
					pend_v_q <= 1'b1;
				end
			end
			if (fl_push) begin
				pend_v_q <= 1'b0;
			end
			// Output register
			if (ev_push || fl_push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_in;
			tv_q  <= time_value;
			per_q <= periodic;
			ev_q  <= event_code;
			own_q <= owner_id;
			fn_q  <= calls_function;
		end
		if (do_eval && key_hit && !key_f_q) begin
			key_own_q <= r_own;
			key_ev_q  <= r_ev;
			key_fn_q  <= r_fn;
			key_cnt_q <= r_cnt;
		end
		if (do_eval && expire && report) begin
			pend_q <= exp_res;
		end
		if (cmd.act && act_res_v) begin
			pend_q <= act_res;
		end
		if (ev_push || fl_push) begin
			out_q      <= pend_q;
			out_last_q <= fl_push;
		end
	end

	assign out_valid    = out_v_q;
	assign result_kind  = out_q.kind;
	assign status       = out_q.status;
	assign slot_index   = out_q.slot;
	assign out_owner    = out_q.owner;
	assign out_event    = out_q.event_code;
	assign out_function = out_q.func;
	assign remaining    = out_q.rem;
	assign last         = out_last_q;

	// Check result bookkeeping
	a_nres_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= stt_pkg::MAX_RES)
		else $error("more expiries reported than allowed");
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !pend_v_q)
		else $error("word started with a pending result");
	a_ack_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act && cmd_q != stt_pkg::CMD_TICK && cmd_q <= stt_pkg::CMD_READ)
		|=> pend_v_q)
		else $error("command closed without a result");
endmodule

// ===== sv/software_timer_table_core.sv =====
// Top level of the software timer table: controller and datapath.
//
// Each command word walks all SLOTS timer slots in the slot RAM, each slot in
// a read state, then an evaluate state that writes it back. An action state
// and a flush state that hands over the final result follow, and the idle
// state that takes the word comes before; evaluate and flush can wait while
// the output side stalls. A tick reports each expired slot in index order, at
// most 16, and gives no result when nothing expires; every other known
// command gives one result. The table starts empty after reset with no
// clearing pass. Input is taken only while no word is in work; a finished
// result may still wait in the output register.
module software_timer_table_core #(
	parameter int SLOTS       = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  cmd,
	input  logic [15:0] time_value,
	input  logic        periodic,
	input  logic [7:0]  event_code,
	input  logic [7:0]  owner_id,
	input  logic        calls_function,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [1:0]  status,
	output logic [3:0]  slot_index,
	output logic [7:0]  out_owner,
	output logic [7:0]  out_event,
	output logic        out_function,
	output logic [15:0] remaining,
	output logic        last
);
	stt_pkg::ctrl_cmd_t ctl;
	stt_pkg::dp_stat_t  st;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (ctl),
		.stat     (st)
	);

	stt_dp #(.SLOTS(SLOTS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl),
		.stat           (st),
		.cmd_in         (cmd),
		.time_value     (time_value),
		.periodic       (periodic),
		.event_code     (event_code),
		.owner_id       (owner_id),
		.calls_function (calls_function),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.status         (status),
		.slot_index     (slot_index),
		.out_owner      (out_owner),
		.out_event      (out_event),
		.out_function   (out_function),
		.remaining      (remaining),
		.last           (last)
	);
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the software timer table core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam int N_RANDOM = 170;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] cmd = stt_pkg::CMD_TICK;
	logic [15:0] time_value = '0;
	logic periodic = 1'b0;
	logic [7:0] event_code = '0;
	logic [7:0] owner_id = '0;
	logic calls_function = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] result_kind;
	logic [1:0] status;
	logic [3:0] slot_index;
	logic [7:0] out_owner;
	logic [7:0] out_event;
	logic out_function;
	logic [15:0] remaining;
	logic last;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic [3:0] slot;
		logic [7:0] owner;
		logic [7:0] event_code;
		logic func;
		logic [15:0] rem;
		logic last;
	} word_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic [15:0] tv;
		logic per;
		logic [7:0] ev;
		logic [7:0] own;
		logic fn;
	} cmd_word_t;

	// Directed row: command and optionally a typed-in expected result
	typedef struct {
		cmd_word_t w;
		bit has_exp;
		word_t exp;
	} row_t;

	always #2 clk = ~clk;

	software_timer_table_core uut (.*);

	// Shadow timer table
	bit tbl_valid[NSLOT];
	bit tbl_enabled[NSLOT];
	logic [15:0] tbl_reload[NSLOT];
	logic [15:0] tbl_count[NSLOT];
	logic [7:0] tbl_event[NSLOT];
	logic [7:0] tbl_owner[NSLOT];
	bit tbl_func[NSLOT];

	word_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet_phase = 1'b0;

	task automatic report_mismatch(input string what, input word_t got, input word_t exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	function automatic word_t make_word(logic [1:0] k, logic [1:0] st, logic [3:0] sl,
			logic [7:0] ow, logic [7:0] ev, logic fn, logic [15:0] rm);
		word_t r;
		r.kind = k; r.status = st; r.slot = sl; r.owner = ow;
		r.event_code = ev; r.func = fn; r.rem = rm; r.last = 1'b1;
		return r;
	endfunction

	function automatic int find_key(cmd_word_t w);
		for (int i = 0; i < NSLOT; i++)
			if (tbl_valid[i] && tbl_owner[i] == w.own && tbl_func[i] == w.fn &&
					(w.fn || tbl_event[i] == w.ev))
				return i;
		return -1;
	endfunction

	function automatic int find_free();
		for (int i = 0; i < NSLOT; i++)
			if (!tbl_valid[i])
				return i;
		return -1;
	endfunction

	function automatic void arm_slot(int i, cmd_word_t w);
		tbl_reload[i] = w.per ? w.tv : 16'd0;
		tbl_count[i] = (w.tv != 0) ? w.tv - 16'd1 : 16'd0;
		tbl_event[i] = w.fn ? 8'd0 : w.ev;
		tbl_owner[i] = w.own;
		tbl_func[i] = w.fn;
		tbl_valid[i] = 1'b1;
		tbl_enabled[i] = 1'b1;
	endfunction

	// Update the shadow table and queue the results the command causes
	function automatic void predict_table(cmd_word_t w);
		int i;
		int n;
		bit any;
		n = 0;
		any = 1'b0;
		i = -1;
		case (w.cmd)
			stt_pkg::CMD_TICK: begin
				for (int s = 0; s < NSLOT; s++) begin
					if (!tbl_valid[s] || !tbl_enabled[s])
						continue;
					if (tbl_count[s] == 0) begin
						word_t r;
						r = make_word(stt_pkg::KIND_EXPIRY, stt_pkg::ST_OK, s[3:0],
							tbl_owner[s], tbl_func[s] ? 8'd0 : tbl_event[s], tbl_func[s],
							16'd0);
						r.last = 1'b0;
						expected_results.push_back(r);
						n++;
						if (tbl_reload[s] == 0)
							tbl_valid[s] = 1'b0;
						else
							tbl_count[s] = tbl_reload[s] - 16'd1;
					end else begin
						tbl_count[s]--;
					end
				end
				if (n > 0)
					expected_results[$].last = 1'b1;
			end
			stt_pkg::CMD_NEW, stt_pkg::CMD_UPDATE, stt_pkg::CMD_UPD_NEW: begin
				if (w.cmd != stt_pkg::CMD_NEW)
					i = find_key(w);
				if (i < 0 && w.cmd != stt_pkg::CMD_UPDATE)
					i = find_free();
				if (i < 0)
					expected_results.push_back(make_word(stt_pkg::KIND_ACK,
						(w.cmd == stt_pkg::CMD_UPDATE) ? stt_pkg::ST_NO_KEY : stt_pkg::ST_FULL,
						0, 0, 0, 0, 0));
				else begin
					arm_slot(i, w);
					expected_results.push_back(make_word(stt_pkg::KIND_ACK, stt_pkg::ST_OK,
						i[3:0], 0, 0, 0, 0));
				end
			end
			stt_pkg::CMD_FREE, stt_pkg::CMD_PAUSE, stt_pkg::CMD_RESUME: begin
				i = find_key(w);
				if (i < 0)
					expected_results.push_back(make_word(stt_pkg::KIND_ACK,
						stt_pkg::ST_NO_KEY, 0, 0, 0, 0, 0));
				else begin
					if (w.cmd == stt_pkg::CMD_FREE)
						tbl_valid[i] = 1'b0;
					else
						tbl_enabled[i] = (w.cmd == stt_pkg::CMD_RESUME);
					expected_results.push_back(make_word(stt_pkg::KIND_ACK, stt_pkg::ST_OK,
						i[3:0], 0, 0, 0, 0));
				end
			end
			stt_pkg::CMD_FREE_OWN: begin
				for (int s = 0; s < NSLOT; s++)
					if (tbl_valid[s] && tbl_owner[s] == w.own && tbl_func[s] == w.fn) begin
						tbl_valid[s] = 1'b0;
						any = 1'b1;
					end
				expected_results.push_back(make_word(stt_pkg::KIND_ACK,
					any ? stt_pkg::ST_OK : stt_pkg::ST_NO_KEY, 0, 0, 0, 0, 0));
			end
			stt_pkg::CMD_READ: begin
				i = find_key(w);
				if (i < 0)
					expected_results.push_back(make_word(stt_pkg::KIND_READ,
						stt_pkg::ST_NO_KEY, 0, 0, 0, 0, 0));
				else
					expected_results.push_back(make_word(stt_pkg::KIND_READ, stt_pkg::ST_OK,
						i[3:0], tbl_owner[i], tbl_func[i] ? 8'd0 : tbl_event[i], tbl_func[i],
						tbl_count[i]));
			end
			default: ;
		endcase
	endfunction

	// Hand one command word to the block, with random gaps ahead
	task automatic send_word(cmd_word_t w);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		cmd <= w.cmd;
		time_value <= w.tv;
		periodic <= w.per;
		event_code <= w.ev;
		owner_id <= w.own;
		calls_function <= w.fn;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_table(w);
	endtask

	function automatic cmd_word_t mk(logic [3:0] c, logic [15:0] tv, logic per,
			logic [7:0] ev, logic [7:0] own, logic fn);
		cmd_word_t w;
		w.cmd = c; w.tv = tv; w.per = per; w.ev = ev; w.own = own; w.fn = fn;
		return w;
	endfunction

	// Random command, mostly keyed to a small pool of owners and events
	function automatic cmd_word_t rand_word();
		cmd_word_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			w.cmd = stt_pkg::CMD_TICK;
		else if (pick < 97)
			w.cmd = 4'($urandom_range(1, 8));
		else
			w.cmd = 4'($urandom_range(9, 15));
		w.tv = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		w.per = 1'($urandom);
		w.fn = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0) begin
			w.ev = 8'($urandom);
			w.own = 8'($urandom);
		end else begin
			w.ev = 8'($urandom_range(0, 2)) | {$urandom_range(0, 1) ? 8'h80 : 8'h00};
			w.own = 8'($urandom_range(0, 3)) | {$urandom_range(0, 1) ? 8'hF0 : 8'h00};
		end
		return w;
	endfunction

	// Output side: random stalls, compare each word with the oldest expectation
	always @(posedge clk) begin
		word_t got;
		word_t exp;
		if (out_valid && out_ready) begin
			got = {result_kind, status, slot_index, out_owner, out_event, out_function,
				remaining, last};
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", got, '0);
			end else begin
				exp = expected_results.pop_front();
				if (got.kind !== exp.kind) report_mismatch("result_kind", got, exp);
				if (got.status !== exp.status) report_mismatch("status", got, exp);
				if (got.slot !== exp.slot) report_mismatch("slot_index", got, exp);
				if (got.owner !== exp.owner) report_mismatch("out_owner", got, exp);
				if (got.event_code !== exp.event_code) report_mismatch("out_event", got, exp);
				if (got.func !== exp.func) report_mismatch("out_function", got, exp);
				if (got.rem !== exp.rem) report_mismatch("remaining", got, exp);
				if (got.last !== exp.last) report_mismatch("last", got, exp);
			end
		end
		if (!arst_n || quiet_phase)
			out_ready <= arst_n;
		else if ($urandom_range(0, 5) == 0)
			out_ready <= ~out_ready;
		else
			out_ready <= out_ready | ($urandom_range(0, 2) == 0);
	end

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		// Directed table: fresh table, extremes, error codes, function kind
		r.has_exp = 1'b1;
		r.w = mk(stt_pkg::CMD_READ, 0, 0, 8'h00, 8'h00, 0);
		r.exp = make_word(stt_pkg::KIND_READ, stt_pkg::ST_NO_KEY, 0, 0, 0, 0, 0);
		rows.push_back(r);
		r.w = mk(stt_pkg::CMD_UPDATE, 5, 1, 8'h01, 8'h01, 0);
		r.exp = make_word(stt_pkg::KIND_ACK, stt_pkg::ST_NO_KEY, 0, 0, 0, 0, 0);
		rows.push_back(r);
		r.w = mk(stt_pkg::CMD_FREE, 0, 0, 8'hFF, 8'hFF, 1);
		r.exp = make_word(stt_pkg::KIND_ACK, stt_pkg::ST_NO_KEY, 0, 0, 0, 0, 0);
		rows.push_back(r);
		r.w = mk(stt_pkg::CMD_FREE_OWN, 0, 0, 8'h00, 8'hFF, 0);
		r.exp = make_word(stt_pkg::KIND_ACK, stt_pkg::ST_NO_KEY, 0, 0, 0, 0, 0);
		rows.push_back(r);
		r.w = mk(stt_pkg::CMD_NEW, 16'hFFFF, 1, 8'hFF, 8'hFF, 0);
		r.exp = make_word(stt_pkg::KIND_ACK, stt_pkg::ST_OK, 0, 0, 0, 0, 0);
		rows.push_back(r);
		r.w = mk(stt_pkg::CMD_READ, 0, 0, 8'hFF, 8'hFF, 0);
		r.exp = make_word(stt_pkg::KIND_READ, stt_pkg::ST_OK, 0, 8'hFF, 8'hFF, 0, 16'hFFFE);
		rows.push_back(r);
		r.has_exp = 1'b0;
		rows.push_back('{mk(stt_pkg::CMD_NEW, 0, 1, 8'hAA, 8'h01, 1), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_NEW, 1, 0, 8'h05, 8'h02, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_NEW, 2, 1, 8'h06, 8'h02, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_READ, 0, 0, 8'h33, 8'h01, 1), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_TICK, 16'hFFFF, 1, 8'hFF, 8'hFF, 1), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_PAUSE, 0, 0, 8'h06, 8'h02, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_RESUME, 0, 0, 8'h06, 8'h02, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_UPD_NEW, 3, 0, 8'h06, 8'h02, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_UPD_NEW, 4, 1, 8'h07, 8'h02, 0), 0, '0});
		rows.push_back('{mk(4'd15, 16'h1234, 1, 8'h11, 8'h22, 1), 0, '0});
		rows.push_back('{mk(4'd9, 0, 0, 0, 0, 0), 0, '0});
		for (int i = 0; i < 3; i++)
			rows.push_back('{mk(stt_pkg::CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_FREE_OWN, 0, 0, 0, 8'h02, 0), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_FREE_OWN, 0, 0, 0, 8'h01, 1), 0, '0});
		rows.push_back('{mk(stt_pkg::CMD_FREE_OWN, 0, 0, 0, 8'hFF, 0), 0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].w);
			// typed-in value must agree with the predictor
			if (rows[i].has_exp && expected_results[$] != rows[i].exp)
				report_mismatch("table row", expected_results[$], rows[i].exp);
		end

		// Fill the table to full, then overflow it, then expire all at once
		for (int i = 0; i < 17; i++)
			send_word(mk(stt_pkg::CMD_NEW, 1, i[0], 8'(i), 8'h40, 0));
		send_word(mk(stt_pkg::CMD_UPD_NEW, 1, 0, 8'h77, 8'h41, 0));
		send_word(mk(stt_pkg::CMD_TICK, 0, 0, 0, 0, 0));
		send_word(mk(stt_pkg::CMD_FREE_OWN, 0, 0, 0, 8'h40, 0));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 30)
				quiet_phase = 1'b1;
			send_word(rand_word());
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
